### rtl/vmos_pkg.sv
package vmos_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_BITS_DEF   = 32;

    localparam int FIELD_BITS      = 32;
    localparam int DEPTH_OUT_BITS  = 7;
    localparam int OFFSET_BITS     = 6;

    localparam logic [3:0] OP_PUSH      = 4'd0;
    localparam logic [3:0] OP_PUSH_PAIR = 4'd1;
    localparam logic [3:0] OP_POP       = 4'd2;
    localparam logic [3:0] OP_POP_PAIR  = 4'd3;
    localparam logic [3:0] OP_DROP      = 4'd4;
    localparam logic [3:0] OP_DROP_PAIR = 4'd5;
    localparam logic [3:0] OP_PEEK      = 4'd6;
    localparam logic [3:0] OP_DUP       = 4'd7;
    localparam logic [3:0] OP_CLEAR     = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_BOUNDS    = 2'd3;

    typedef struct packed {
        logic [3:0]             operation;
        logic [FIELD_BITS-1:0]  value_in;
        logic [FIELD_BITS-1:0]  address_in;
        logic [OFFSET_BITS-1:0] peek_offset;
    } item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic [FIELD_BITS-1:0]     value_out;
        logic [FIELD_BITS-1:0]     address_out;
        logic [DEPTH_OUT_BITS-1:0] depth_out;
    } result_t;

endpackage

### rtl/vm_operand_stack_top.sv
// Operand stack: one operation per beat, one result beat per operation.
// A result is loaded by the respond step. Push, drop, drop pair, clear, unused codes and refused
// operations go from execute straight to respond; pop, peek, dup and push pair pass one more step, pop pair two.
// Items are taken one at a time, in steps: accept, execute and respond, plus the extra steps above;
// a stalled result beat holds the respond step, and no new item is taken until it is done.
// Reset clears the depth, the sequencer and the result valid; the stack RAM is not cleared.
module vm_operand_stack_top
    import vmos_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [AW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    vmos_ctrl #(
        .STACK_DEPTH (STACK_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    vmos_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (WORD_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

### rtl/vmos_ram.sv
module vmos_ram
    import vmos_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int WIDTH = WORD_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/vmos_ctrl.sv
module vmos_ctrl
    import vmos_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int WORD_BITS   = WORD_BITS_DEF,
    localparam int AW = $clog2(STACK_DEPTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    output logic [AW-1:0]        rd_addr,
    input  logic [WORD_BITS-1:0] rd_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CW = (DW > OFFSET_BITS) ? DW : OFFSET_BITS;
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);
    localparam logic [DW:0]   DEPTH_LIMIT = (DW + 1)'(STACK_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PAIRW,
        S_POP2,
        S_RDV,
        S_DUPW,
        S_RESP
    } state_t;

    state_t                state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [DW-1:0]         depth_reg, depth_next;
    logic [1:0]            status_reg, status_next;
    logic [FIELD_BITS-1:0] vout_reg, vout_next;
    logic [FIELD_BITS-1:0] aout_reg, aout_next;
    result_t               out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  full, pair_full, empty, below_two, peek_oob;
    logic [CW-1:0]         peek_index;

    assign full       = (depth_reg == DEPTH_FULL);
    assign pair_full  = ({1'b0, depth_reg} + (DW + 1)'(2)) > DEPTH_LIMIT;
    assign empty      = (depth_reg == '0);
    assign below_two  = (depth_reg < DW'(2));
    assign peek_oob   = CW'(item_reg.peek_offset) >= CW'(depth_reg);
    assign peek_index = CW'(depth_reg) - CW'(item_reg.peek_offset) - CW'(1);

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        depth_next     = depth_reg;
        status_next    = status_reg;
        vout_next      = vout_reg;
        aout_next      = aout_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = depth_reg[AW-1:0];
        wr_data        = WORD_BITS'(item_reg.value_in);
        rd_addr        = AW'(depth_reg - DW'(1));

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                vout_next   = '0;
                aout_next   = '0;
                state_next  = S_RESP;
                unique case (item_reg.operation)
                    OP_PUSH:
                    begin
                        if (full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    OP_PUSH_PAIR:
                    begin
                        if (pair_full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            depth_next = depth_reg + DW'(1);
                            state_next = S_PAIRW;
                        end
                    end
                    OP_POP:
                    begin
                        if (empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg - DW'(1);
                            state_next = S_RDV;
                        end
                    end
                    OP_POP_PAIR:
                    begin
                        if (below_two)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg - DW'(2);
                            state_next = S_POP2;
                        end
                    end
                    OP_DROP:
                    begin
                        if (empty)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg - DW'(1);
                        end
                    end
                    OP_DROP_PAIR:
                    begin
                        if (below_two)
                        begin
                            status_next = ST_UNDERFLOW;
                        end
                        else
                        begin
                            depth_next = depth_reg - DW'(2);
                        end
                    end
                    OP_PEEK:
                    begin
                        if (peek_oob)
                        begin
                            status_next = ST_BOUNDS;
                        end
                        else
                        begin
                            rd_addr    = peek_index[AW-1:0];
                            state_next = S_RDV;
                        end
                    end
                    OP_DUP:
                    begin
                        if (empty)
                        begin
                            status_next = ST_BOUNDS;
                        end
                        else if (full)
                        begin
                            status_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            state_next = S_DUPW;
                        end
                    end
                    OP_CLEAR:
                    begin
                        depth_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PAIRW:
            begin
                // The address word goes on top of the function word.
                wr_en      = 1'b1;
                wr_data    = WORD_BITS'(item_reg.address_in);
                depth_next = depth_reg + DW'(1);
                state_next = S_RESP;
            end
            S_POP2:
            begin
                // Depth already dropped by two, so it now points at the function word.
                aout_next  = FIELD_BITS'(rd_data);
                rd_addr    = depth_reg[AW-1:0];
                state_next = S_RDV;
            end
            S_RDV:
            begin
                vout_next  = FIELD_BITS'(rd_data);
                state_next = S_RESP;
            end
            S_DUPW:
            begin
                wr_en      = 1'b1;
                wr_data    = rd_data;
                depth_next = depth_reg + DW'(1);
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_next.status      = status_reg;
                    out_next.value_out   = vout_reg;
                    out_next.address_out = aout_reg;
                    out_next.depth_out   = DEPTH_OUT_BITS'(depth_reg);
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            depth_reg     <= '0;
            status_reg    <= ST_OK;
            vout_reg      <= '0;
            aout_reg      <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            depth_reg     <= depth_next;
            status_reg    <= status_next;
            vout_reg      <= vout_next;
            aout_reg      <= aout_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_FULL)
        else $error("stack depth exceeds capacity");

    a_write_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr == depth_reg[AW-1:0]) && !full)
        else $error("stack write away from the top slot");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_EXEC))
        else $error("accepted beat not executed");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && status_reg != ST_OK) |-> (vout_reg == '0 && aout_reg == '0))
        else $error("refused operation returns data");

    a_load_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result beat loaded outside the response step");
`endif

endmodule
